[hw/rtl/bzr_pkg.sv]
// ----------------------------------------------------------------------------
// bzr_pkg
// Shared types and constants of the barycentric z-buffer rasterizer.
// ----------------------------------------------------------------------------
package bzr_pkg;

   localparam int COORD_W = 16;             // 12.4 signed
   localparam int DEPTH_W = 24;             // signed depth
   localparam int COLOR_W = 24;
   localparam int PIX_W   = 8;
   localparam int EDGE_W  = 17;             // corner differences
   localparam int ACC_W   = 36;             // det, nu, nv
   localparam int WT_W    = 17;             // Q1.16 weight, 0..65536
   localparam int SUM_W   = 42;             // depth sum
   localparam int OPA_W   = 25;
   localparam int OPB_W   = 18;
   localparam int PROD_W  = OPA_W + OPB_W;
   localparam int DIV_STEPS = WT_W;

   localparam logic [DEPTH_W-1:0] DEPTH_FLOOR = 24'h800000;
   localparam logic [3:0]         HALF_PIXEL  = 4'd8;   // 0.5 in 12.4
   localparam logic [WT_W-1:0]    WT_ONE      = 17'd65536;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_SIGN  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_ZMUL  = 8'b0010_0000,
      ST_CMP   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic            done;
      logic [WT_W-1:0] u;
      logic [WT_W-1:0] v;
   } div_stat_type;

endpackage

[hw/rtl/bzr_ram.sv]
// ----------------------------------------------------------------------------
// bzr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bzr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bzr_div.sv]
// ----------------------------------------------------------------------------
// bzr_div
// Radix-2 restoring divider, two lanes sharing one divisor: u = nu*2^16/det
// and v = nv*2^16/det, one quotient bit per cycle. Needs 0 <= nu, nv <= det.
// ----------------------------------------------------------------------------
module bzr_div import bzr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ACC_W-1:0]  det,
   input  logic [ACC_W-1:0]  nu,
   input  logic [ACC_W-1:0]  nv,
   output div_stat_type      stat
);

   localparam int REM_W = ACC_W + 1;
   localparam int CNT_W = $clog2(DIV_STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]  den_ff, den_in;
   logic [REM_W-1:0]  ru_ff, ru_in, rv_ff, rv_in;
   logic [WT_W-1:0]   qu_ff, qu_in, qv_ff, qv_in;
   logic              bit_u, bit_v;
   logic [REM_W-1:0]  du, dv;

   always_comb begin
      bit_u   = (ru_ff >= den_ff);
      bit_v   = (rv_ff >= den_ff);
      du      = bit_u ? (ru_ff - den_ff) : ru_ff;
      dv      = bit_v ? (rv_ff - den_ff) : rv_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      ru_in   = ru_ff;
      rv_in   = rv_ff;
      qu_in   = qu_ff;
      qv_in   = qv_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = {1'b0, det};
         ru_in   = {1'b0, nu};
         rv_in   = {1'b0, nv};
      end else if (busy_ff) begin
         ru_in  = {du[REM_W-2:0], 1'b0};
         rv_in  = {dv[REM_W-2:0], 1'b0};
         qu_in  = {qu_ff[WT_W-2:0], bit_u};
         qv_in  = {qv_ff[WT_W-2:0], bit_v};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      ru_ff  <= ru_in;
      rv_ff  <= rv_in;
      qu_ff  <= qu_in;
      qv_ff  <= qv_in;
   end

   assign stat.done = done_ff;
   assign stat.u    = qu_ff;
   assign stat.v    = qv_ff;

endmodule

[hw/rtl/barycentric_zbuffer_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// barycentric_zbuffer_rasterizer_core
// Triangle pixel tester with barycentric depth interpolation and z-buffer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the depth store to the most negative depth,
// one entry per cycle over min(FRAME_WIDTH,256) * min(FRAME_HEIGHT,256)
// entries (65536 at the defaults); req_tready stays low meanwhile. A load
// word (tuser = 0) stores one corner and the triangle color; slot 3 stores
// nothing. A covered pixel word passes through the accept cycle, six
// products on the one shared 25x18 multiplier for det, nu and nv, a sign
// fix, the two-lane restoring divider for the weights u and v (17 quotient
// bits plus the done flag), three more products for the depth sum, then
// the depth compare and, for a nearer pixel in the frame, the store write,
// and the hand-off to the result register. A pixel that is not covered
// skips the divider and the depth sum. One word is in work at a time; the
// result register lets a new word in while the previous result still waits
// on rsp_tready. Exactly one result word per input word.
module barycentric_zbuffer_rasterizer_core import bzr_pkg::*; #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] vertex_slot, [17:2] vertex_x, [33:18] vertex_y,
   // [57:34] vertex_depth, [81:58] fill_color, [89:82] pixel_x,
   // [97:90] pixel_y, rest zero
   input  logic [103:0] req_tdata,
   // [0] mode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] out_x, [15:8] out_y, [39:16] out_color, [63:40] out_depth
   output logic [63:0]  rsp_tdata,
   // [0] write_pixel, [1] covered
   output logic [1:0]   rsp_tuser
);

   // pixel ports are 8 bits, so only the first 256 rows/columns are reachable
   localparam int EFF_W = (FRAME_WIDTH  < 256) ? FRAME_WIDTH  : 256;
   localparam int EFF_H = (FRAME_HEIGHT < 256) ? FRAME_HEIGHT : 256;
   localparam int DEPTH = EFF_W * EFF_H;
   localparam int AW    = $clog2(DEPTH);

   // input word fields
   logic               in_mode;
   logic [1:0]         in_slot;
   logic [COORD_W-1:0] in_x, in_y;
   logic [DEPTH_W-1:0] in_depth;
   logic [COLOR_W-1:0] in_color;
   logic [PIX_W-1:0]   in_px, in_py;

   assign in_mode  = req_tuser;
   assign in_slot  = req_tdata[1:0];
   assign in_x     = req_tdata[17:2];
   assign in_y     = req_tdata[33:18];
   assign in_depth = req_tdata[57:34];
   assign in_color = req_tdata[81:58];
   assign in_px    = req_tdata[89:82];
   assign in_py    = req_tdata[97:90];

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [3:0]         cnt_ff, cnt_in;

   logic [COORD_W-1:0] cx_ff [3];
   logic [COORD_W-1:0] cy_ff [3];
   logic [DEPTH_W-1:0] cd_ff [3];
   logic [COLOR_W-1:0] color_ff;

   logic [PIX_W-1:0]   px_ff, py_ff;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               in_frame_ff, in_frame_in;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  det_ff, det_in, nu_ff, nu_in, nv_ff, nv_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [WT_W-1:0]          u_ff, u_in, v_ff, v_in;

   // pending result, moved into the output register in ST_DONE
   logic               r_wr_ff, r_wr_in, r_cov_ff, r_cov_in;
   logic [PIX_W-1:0]   r_x_ff, r_x_in, r_y_ff, r_y_in;
   logic [COLOR_W-1:0] r_color_ff, r_color_in;
   logic [DEPTH_W-1:0] r_depth_ff, r_depth_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   logic               accept;
   logic               load_corner;

   // edge terms of the cross products
   logic signed [EDGE_W-1:0] ex0, ex1, ex2, ey0, ey1, ey2;
   logic signed [OPA_W-1:0]  opa;
   logic signed [OPB_W-1:0]  opb;
   logic [WT_W-1:0]          w_wt;
   logic [3:0]               acc_idx;
   logic signed [ACC_W-1:0]  acc_term;

   // sign fix
   logic signed [ACC_W-1:0]  adet, anu, anv;
   logic signed [ACC_W:0]    anw;
   logic                     cov;

   // depth compare
   logic signed [SUM_W-1:0]  sum_bias;
   logic signed [DEPTH_W-1:0] z_val;
   logic                     nearer;

   // divider and depth store
   logic               div_start;
   div_stat_type       div_stat;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [DEPTH_W-1:0] ram_wr_data;
   logic [DEPTH_W-1:0] ram_rd_data;

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign load_corner = accept && (in_mode == MODE_LOAD) && (in_slot != 2'd3);

   always_comb begin
      ex0 = {cx_ff[1][COORD_W-1], cx_ff[1]} - {cx_ff[0][COORD_W-1], cx_ff[0]};
      ex1 = {cx_ff[2][COORD_W-1], cx_ff[2]} - {cx_ff[0][COORD_W-1], cx_ff[0]};
      ex2 = {cx_ff[0][COORD_W-1], cx_ff[0]} - {5'd0, px_ff, HALF_PIXEL};
      ey0 = {cy_ff[1][COORD_W-1], cy_ff[1]} - {cy_ff[0][COORD_W-1], cy_ff[0]};
      ey1 = {cy_ff[2][COORD_W-1], cy_ff[2]} - {cy_ff[0][COORD_W-1], cy_ff[0]};
      ey2 = {cy_ff[0][COORD_W-1], cy_ff[0]} - {5'd0, py_ff, HALF_PIXEL};
      w_wt = WT_ONE - u_ff - v_ff;
   end

   // shared multiplier operand select
   always_comb begin
      opa = '0;
      opb = '0;
      if (state_ff == ST_ZMUL) begin
         case (cnt_ff)
            4'd0: begin
               opa = OPA_W'(signed'(cd_ff[0]));
               opb = {1'b0, w_wt};
            end
            4'd1: begin
               opa = OPA_W'(signed'(cd_ff[1]));
               opb = {1'b0, u_ff};
            end
            4'd2: begin
               opa = OPA_W'(signed'(cd_ff[2]));
               opb = {1'b0, v_ff};
            end
            default: begin
               opa = '0;
               opb = '0;
            end
         endcase
      end else begin
         case (cnt_ff)
            4'd0: begin
               opa = OPA_W'(ex0);
               opb = OPB_W'(ey1);
            end
            4'd1: begin
               opa = OPA_W'(ex1);
               opb = OPB_W'(ey0);
            end
            4'd2: begin
               opa = OPA_W'(ex1);
               opb = OPB_W'(ey2);
            end
            4'd3: begin
               opa = OPA_W'(ex2);
               opb = OPB_W'(ey1);
            end
            4'd4: begin
               opa = OPA_W'(ex2);
               opb = OPB_W'(ey0);
            end
            4'd5: begin
               opa = OPA_W'(ex0);
               opb = OPB_W'(ey2);
            end
            default: begin
               opa = '0;
               opb = '0;
            end
         endcase
      end
   end

   always_comb begin
      acc_idx  = cnt_ff - 4'd1;
      acc_term = prod_ff[ACC_W-1:0];
      adet = det_ff[ACC_W-1] ? -det_ff : det_ff;
      anu  = det_ff[ACC_W-1] ? -nu_ff  : nu_ff;
      anv  = det_ff[ACC_W-1] ? -nv_ff  : nv_ff;
      anw  = {adet[ACC_W-1], adet} - {anu[ACC_W-1], anu} - {anv[ACC_W-1], anv};
      cov  = (adet != '0) && !anu[ACC_W-1] && !anv[ACC_W-1] && !anw[ACC_W];
      // floor((sum + 32768) / 65536): sum / 65536 rounded half up
      sum_bias = sum_ff + SUM_W'(32768);
      z_val    = sum_bias[DEPTH_W+15:16];
      nearer   = signed'(ram_rd_data) < z_val;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cnt_in      = cnt_ff;
      addr_in     = addr_ff;
      in_frame_in = in_frame_ff;
      prod_in     = opa * opb;
      det_in      = det_ff;
      nu_in       = nu_ff;
      nv_in       = nv_ff;
      sum_in      = sum_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      r_wr_in     = r_wr_ff;
      r_cov_in    = r_cov_ff;
      r_x_in      = r_x_ff;
      r_y_in      = r_y_ff;
      r_color_in  = r_color_ff;
      r_depth_in  = r_depth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_start    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = z_val;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = DEPTH_FLOOR;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               r_wr_in    = 1'b0;
               r_cov_in   = 1'b0;
               r_color_in = '0;
               r_depth_in = '0;
               r_x_in     = '0;
               r_y_in     = '0;
               if (in_mode == MODE_PIXEL) begin
                  r_x_in      = in_px;
                  r_y_in      = in_py;
                  addr_in     = AW'(32'(in_py) * EFF_W + 32'(in_px));
                  in_frame_in = (32'(in_px) < EFF_W) && (32'(in_py) < EFF_H);
                  cnt_in      = '0;
                  det_in      = '0;
                  nu_in       = '0;
                  nv_in       = '0;
                  state_in    = ST_MUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            // product k issued at count k, accumulated at count k+1
            if (cnt_ff != 4'd0) begin
               case (acc_idx[2:1])
                  2'd0: det_in = acc_idx[0] ? det_ff - acc_term : det_ff + acc_term;
                  2'd1: nu_in  = acc_idx[0] ? nu_ff  - acc_term : nu_ff  + acc_term;
                  2'd2: nv_in  = acc_idx[0] ? nv_ff  - acc_term : nv_ff  + acc_term;
                  default: det_in = det_ff;
               endcase
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd6) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            det_in = adet;
            nu_in  = anu;
            nv_in  = anv;
            if (cov) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               u_in     = div_stat.u;
               v_in     = div_stat.v;
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_ZMUL;
            end
         end
         ST_ZMUL: begin
            if (cnt_ff != 4'd0) begin
               sum_in = sum_ff + prod_ff[SUM_W-1:0];
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            r_cov_in   = 1'b1;
            r_depth_in = z_val;
            if (in_frame_ff && nearer) begin
               ram_wr_en  = 1'b1;
               r_wr_in    = 1'b1;
               r_color_in = color_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {r_depth_ff, r_color_ff, r_y_ff, r_x_ff};
               rsp_user_in  = {r_cov_ff, r_wr_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            cx_ff[i] <= '0;
            cy_ff[i] <= '0;
            cd_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_corner) begin
            cx_ff[in_slot] <= in_x;
            cy_ff[in_slot] <= in_y;
            cd_ff[in_slot] <= in_depth;
            color_ff       <= in_color;
         end
      end
      if (accept) begin
         px_ff <= in_px;
         py_ff <= in_py;
      end
      cnt_ff      <= cnt_in;
      addr_ff     <= addr_in;
      in_frame_ff <= in_frame_in;
      prod_ff     <= prod_in;
      det_ff      <= det_in;
      nu_ff       <= nu_in;
      nv_ff       <= nv_in;
      sum_ff      <= sum_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      r_wr_ff     <= r_wr_in;
      r_cov_ff    <= r_cov_in;
      r_x_ff      <= r_x_in;
      r_y_ff      <= r_y_in;
      r_color_ff  <= r_color_in;
      r_depth_ff  <= r_depth_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   bzr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .det   (det_in),
      .nu    (nu_in),
      .nv    (nv_in),
      .stat  (div_stat)
   );

   bzr_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (DEPTH)
   ) u_zstore (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // depth store is written only by the clear sweep or a passing pixel
   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_CMP))
      else $error("depth store write outside clear or compare");

   // a written pixel is always a covered one
   a_wr_cov: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1] || !rsp_tuser[0]))
      else $error("write_pixel without covered");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider done outside divide phase");

   // a result is loaded only when the output register is free or being taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending result word overwritten");

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench of the barycentric z-buffer rasterizer core.
// ----------------------------------------------------------------------------
// A table of directed words runs first. Random triangles then follow, each
// with a burst of pixels around it, mixed with noise words. A predictor
// follows every accepted word, keeps its own corners, color and depth store,
// and queues the expected result. Results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bzr_pkg::*;

   localparam int NUM_RANDOM  = 2000;
   localparam int QUIET_TAIL  = 200;    // last words run with no idling
   localparam int HOLD_AFTER  = 300;    // long receiver hold starts here
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 100;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic                      mode;
      logic [1:0]                slot;
      logic signed [COORD_W-1:0] vx;
      logic signed [COORD_W-1:0] vy;
      logic signed [DEPTH_W-1:0] vd;
      logic [COLOR_W-1:0]        col;
      logic [PIX_W-1:0]          px;
      logic [PIX_W-1:0]          py;
   } word_type;

   typedef struct {
      logic                      wr;
      logic                      cov;
      logic [PIX_W-1:0]          ox;
      logic [PIX_W-1:0]          oy;
      logic [COLOR_W-1:0]        ocol;
      logic signed [DEPTH_W-1:0] odep;
   } shade_type;

   typedef struct {
      word_type  w;
      logic      typed;
      shade_type res;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   barycentric_zbuffer_rasterizer_core u_top (.*);

   initial forever #1 clock = ~clock;

   // predictor state
   logic signed [COORD_W-1:0] tri_x [3];
   logic signed [COORD_W-1:0] tri_y [3];
   logic signed [DEPTH_W-1:0] tri_z [3];
   logic [COLOR_W-1:0]        tri_color;
   logic signed [DEPTH_W-1:0] zbuf [65536];

   shade_type pending[$];
   int        errors = 0;
   int        accepted = 0;
   logic      quiet = 1'b0;
   // typed expectation that travels with the word on the bus
   logic      cur_typed = 1'b0;
   shade_type cur_res;

   function automatic shade_type shade_word(word_type w);
      shade_type r;
      longint ax, ay, e0x, e1x, e2x, e0y, e1y, e2y, det, nu, nv, nw, u, v, sum, z;
      r = '{default: '0};
      if (w.mode == MODE_LOAD) begin
         if (w.slot != 2'd3) begin
            tri_x[w.slot] = w.vx;
            tri_y[w.slot] = w.vy;
            tri_z[w.slot] = w.vd;
            tri_color     = w.col;
         end
         return r;
      end
      r.ox = w.px;
      r.oy = w.py;
      ax  = tri_x[0];
      ay  = tri_y[0];
      e0x = longint'(tri_x[1]) - ax;
      e1x = longint'(tri_x[2]) - ax;
      e2x = ax - (longint'(w.px) * 16 + 8);
      e0y = longint'(tri_y[1]) - ay;
      e1y = longint'(tri_y[2]) - ay;
      e2y = ay - (longint'(w.py) * 16 + 8);
      det = e0x * e1y - e1x * e0y;
      nu  = e1x * e2y - e2x * e1y;
      nv  = e2x * e0y - e0x * e2y;
      if (det < 0) begin
         det = -det;
         nu  = -nu;
         nv  = -nv;
      end
      nw = det - nu - nv;
      if (det == 0 || nu < 0 || nv < 0 || nw < 0) return r;
      u   = (nu * 65536) / det;
      v   = (nv * 65536) / det;
      sum = longint'(tri_z[0]) * (65536 - u - v) + longint'(tri_z[1]) * u
          + longint'(tri_z[2]) * v;
      z   = (sum + 32768) >>> 16;
      r.cov  = 1'b1;
      r.odep = z[DEPTH_W-1:0];
      // frame is 256 x 256, so every 8-bit pixel lies inside it
      if (longint'(zbuf[{w.py, w.px}]) < z) begin
         zbuf[{w.py, w.px}] = z[DEPTH_W-1:0];
         r.wr   = 1'b1;
         r.ocol = tri_color;
      end
      return r;
   endfunction

   // input acceptance and result checking, both on the rising edge
   always @(posedge clock) begin
      shade_type e, got, p;
      word_type  w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.wr   = rsp_tuser[0];
         got.cov  = rsp_tuser[1];
         got.ox   = rsp_tdata[7:0];
         got.oy   = rsp_tdata[15:8];
         got.ocol = rsp_tdata[39:16];
         got.odep = rsp_tdata[63:40];
         if (pending.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            e = pending.pop_front();
            if (got.wr !== e.wr) begin
               $error("write_pixel exp %0d got %0d", e.wr, got.wr); errors++;
            end
            if (got.cov !== e.cov) begin
               $error("covered exp %0d got %0d", e.cov, got.cov); errors++;
            end
            if (got.ox !== e.ox) begin
               $error("out_x exp %0d got %0d", e.ox, got.ox); errors++;
            end
            if (got.oy !== e.oy) begin
               $error("out_y exp %0d got %0d", e.oy, got.oy); errors++;
            end
            if (got.ocol !== e.ocol) begin
               $error("out_color exp %h got %h", e.ocol, got.ocol); errors++;
            end
            if (got.odep !== e.odep) begin
               $error("out_depth exp %0d got %0d", e.odep, got.odep); errors++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         w.mode = req_tuser;
         w.slot = req_tdata[1:0];
         w.vx   = req_tdata[17:2];
         w.vy   = req_tdata[33:18];
         w.vd   = req_tdata[57:34];
         w.col  = req_tdata[81:58];
         w.px   = req_tdata[89:82];
         w.py   = req_tdata[97:90];
         p = shade_word(w);
         pending.push_back(cur_typed ? cur_res : p);
         accepted++;
      end
   end

   task automatic send_word(word_type w, logic typed, shade_type res);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 17);
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_tuser  = w.mode;
      req_tdata  = {6'd0, w.py, w.px, w.col, w.vd, w.vy, w.vx, w.slot};
      cur_typed  = typed;
      cur_res    = res;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   function automatic word_type load_w(logic [1:0] s, int x, int y, int d, int c);
      word_type w;
      w.mode = MODE_LOAD;
      w.slot = s;
      w.vx   = COORD_W'(x);
      w.vy   = COORD_W'(y);
      w.vd   = DEPTH_W'(d);
      w.col  = COLOR_W'(c);
      w.px   = '0;
      w.py   = '0;
      return w;
   endfunction

   function automatic word_type pix_w(int x, int y);
      word_type w;
      w.mode = MODE_PIXEL;
      w.slot = '0;
      w.vx   = '0;
      w.vy   = '0;
      w.vd   = '0;
      w.col  = '0;
      w.px   = PIX_W'(x);
      w.py   = PIX_W'(y);
      return w;
   endfunction

   // receiver: random stall bursts, one long hold, none near the end
   initial begin
      int  n;
      bit  held;
      held = 0;
      @(negedge clock);
      forever begin
         if (!held && accepted >= HOLD_AFTER) begin
            held = 1;
            rsp_tready = 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("[barycentric_zbuffer_rasterizer_core] ERROR");
            $finish;
         end
      end
   end

   initial begin
      row_type   rows[$];
      shade_type none, z;
      word_type  w;
      int        i, k, npix, bx, by, sz, sent;
      for (i = 0; i < 3; i++) begin
         tri_x[i] = '0; tri_y[i] = '0; tri_z[i] = '0;
      end
      tri_color = '0;
      for (i = 0; i < 65536; i++) zbuf[i] = DEPTH_FLOOR;
      none = '{default: '0};

      // pixel after reset: all corners zero, degenerate
      z = none; z.ox = 8'd5; z.oy = 8'd7;
      rows.push_back('{pix_w(5, 7), 1'b1, z});
      // loads return an all-zero word; extremes of every vertex field
      rows.push_back('{load_w(0, -32768, 32767, -8388608, 24'hFFFFFF), 1'b1, none});
      rows.push_back('{load_w(1, 32767, -32768, 8388607, 24'h000000), 1'b1, none});
      rows.push_back('{load_w(2, 0, 0, 0, 24'hA5A55A), 1'b1, none});
      rows.push_back('{pix_w(255, 255), 1'b0, none});
      rows.push_back('{pix_w(0, 0), 1'b0, none});
      // unused slot must leave the triangle and color alone
      rows.push_back('{load_w(3, 1234, -999, 77, 24'h123456), 1'b1, none});
      rows.push_back('{pix_w(128, 0), 1'b0, none});
      // counterclockwise right triangle, 64 pixels a side
      rows.push_back('{load_w(0, 0, 0, 1000, 24'h112233), 1'b1, none});
      rows.push_back('{load_w(1, 1024, 0, 2000, 24'h112233), 1'b1, none});
      rows.push_back('{load_w(2, 0, 1024, 3000, 24'h445566), 1'b1, none});
      rows.push_back('{pix_w(1, 1), 1'b0, none});      // inside, writes
      rows.push_back('{pix_w(1, 1), 1'b0, none});      // same depth, not nearer
      rows.push_back('{pix_w(100, 100), 1'b0, none});  // outside
      rows.push_back('{pix_w(63, 0), 1'b0, none});     // near the edge
      // same triangle wound clockwise, nearer: negative determinant
      rows.push_back('{load_w(1, 0, 1024, 9000, 24'h778899), 1'b1, none});
      rows.push_back('{load_w(2, 1024, 0, 8000, 24'h778899), 1'b1, none});
      rows.push_back('{pix_w(1, 1), 1'b0, none});
      rows.push_back('{pix_w(30, 20), 1'b0, none});
      // all corners on one line
      rows.push_back('{load_w(2, 2048, 2048, 5, 24'h0F0F0F), 1'b1, none});
      rows.push_back('{load_w(1, 1024, 1024, 5, 24'h0F0F0F), 1'b1, none});
      rows.push_back('{pix_w(64, 64), 1'b0, none});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

      sent = 0;
      while (sent < NUM_RANDOM) begin
         if (sent >= NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
         if ($urandom_range(0, 9) < 8) begin
            // small triangle with a burst of pixels around it
            bx = $urandom_range(0, 255);
            by = $urandom_range(0, 255);
            sz = $urandom_range(1, 12);
            for (k = 0; k < 3; k++) begin
               w = load_w(2'(k),
                  16 * (bx + $urandom_range(0, 2 * sz) - sz) + $urandom_range(0, 15),
                  16 * (by + $urandom_range(0, 2 * sz) - sz) + $urandom_range(0, 15),
                  $urandom(), $urandom());
               send_word(w, 1'b0, none);
               sent++;
            end
            npix = $urandom_range(6, 15);
            for (k = 0; k < npix; k++) begin
               w = pix_w((bx + $urandom_range(0, 2 * sz) - sz) & 8'hFF,
                         (by + $urandom_range(0, 2 * sz) - sz) & 8'hFF);
               send_word(w, 1'b0, none);
               sent++;
            end
         end else begin
            // noise: any field, any slot, any pixel
            w.mode = 1'($urandom());
            w.slot = 2'($urandom());
            w.vx   = COORD_W'($urandom());
            w.vy   = COORD_W'($urandom());
            w.vd   = DEPTH_W'($urandom());
            w.col  = COLOR_W'($urandom());
            w.px   = PIX_W'($urandom());
            w.py   = PIX_W'($urandom());
            send_word(w, 1'b0, none);
            sent++;
         end
      end
      @(negedge clock);
      req_tvalid = 1'b0;
      cur_typed  = 1'b0;

      while (pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && pending.size() == 0)
         $display("[barycentric_zbuffer_rasterizer_core] OK");
      else
         $display("[barycentric_zbuffer_rasterizer_core] ERROR");
      $finish;
   end

endmodule
